[src/prra_pkg.sv]
// prra_pkg: shared constants, types and a helper function of the priority
// round-robin arbiter. No dependencies.
package prra_pkg;

  localparam int PORTS_DEF  = 32;
  localparam int LANES_DEF  = 8;
  localparam int QUEUES_DEF = 32;

  // Fixed widths of the transaction fields.
  localparam int MAX_LANES   = 8;
  localparam int MAX_QUEUES  = 32;
  localparam int PORT_W      = 5;
  localparam int LANE_W      = 3;
  localparam int PTR_W       = 5;
  localparam int LANE_CNT_W  = 4;

  localparam logic [LANE_CNT_W-1:0] LANE_COUNT_RST = 4'd8;

  // Result of the round-robin pick within one lane.
  typedef struct packed {
    logic             hit;
    logic [PTR_W-1:0] queue;
    logic [PTR_W-1:0] ptr_next;
  } rr_grant_t;

  // Index of the lowest set bit, 0 when none is set.
  function automatic logic [PTR_W-1:0] lowest_set(input logic [MAX_QUEUES-1:0] v);
    logic [PTR_W-1:0] idx;
    idx = '0;
    for (int i = MAX_QUEUES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = PTR_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[src/prra_ptr_mem.sv]
// prra_ptr_mem: round-robin pointer memory, one row of per-lane pointers per
// output port, with a registered read. Depends on prra_pkg.
module prra_ptr_mem
  import prra_pkg::*;
#(
  parameter int PORTS = PORTS_DEF,
  parameter int LANES = LANES_DEF,
  localparam int PORT_AW = (PORTS > 1) ? $clog2(PORTS) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [PORT_AW-1:0]              rd_addr,
  output logic [LANES-1:0][PTR_W-1:0]     rd_row,
  input  logic                            wr_en,
  input  logic [PORT_AW-1:0]              wr_addr,
  input  logic [LANES-1:0][PTR_W-1:0]     wr_row
);

  logic [LANES-1:0][PTR_W-1:0] mem [PORTS];
  logic [PORTS-1:0]            row_valid;
  logic [LANES-1:0][PTR_W-1:0] rd_data;
  logic                        rd_valid;

  // Rows never written read as all-zero pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= row_valid[rd_addr];
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule

[src/prra_rr_pick.sv]
// prra_rr_pick: round-robin pick of the first eligible queue at or after the
// stored pointer, wrapping. Depends on prra_pkg.
module prra_rr_pick
  import prra_pkg::*;
#(
  parameter int QUEUES = QUEUES_DEF
) (
  input  logic [QUEUES-1:0] mask,
  input  logic [PTR_W-1:0]  start,
  output rr_grant_t         grant
);

  logic [MAX_QUEUES-1:0] mask_all;
  logic [MAX_QUEUES-1:0] mask_hi;
  logic [PTR_W-1:0]      q;

  always_comb begin
    mask_all = MAX_QUEUES'(mask);
    mask_hi  = '0;
    for (int i = 0; i < QUEUES; i++) begin
      mask_hi[i] = mask[i] && (PTR_W'(i) >= start);
    end
  end

  // Take the upper part first, wrap to the bottom otherwise.
  assign q = (|mask_hi) ? lowest_set(mask_hi) : lowest_set(mask_all);

  assign grant.hit      = |mask;
  assign grant.queue    = q;
  assign grant.ptr_next = (q == PTR_W'(QUEUES - 1)) ? '0 : q + PTR_W'(1);

endmodule

[src/priority_round_robin_arbiter.sv]
// priority_round_robin_arbiter: top level, lane selection, sequencer and
// output register. Depends on prra_pkg, prra_ptr_mem and prra_rr_pick.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  input    | in_valid / in_stall    | out_port, req_lane0 .. req_lane7
//  output   | out_valid / out_stall  | granted, grant_lane, grant_queue
//  config   | cfg_wr_en              | cfg_wr_data (lane_count)
//
// Each transaction passes through two states: IDLE picks the lane and reads
// the port's pointer row, CALC runs the round-robin search and writes it back.
// Because of the read-modify-write of the pointer memory, a new transaction is
// taken only in IDLE. A full output register that is stalled holds CALC.
// Synchronous reset zeroes all pointers (through row valid bits) and sets
// lane_count to 8.
module priority_round_robin_arbiter
  import prra_pkg::*;
#(
  parameter int PORTS  = PORTS_DEF,
  parameter int LANES  = LANES_DEF,
  parameter int QUEUES = QUEUES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [LANE_CNT_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PORT_W-1:0]     out_port,
  input  logic [31:0]           req_lane0,
  input  logic [31:0]           req_lane1,
  input  logic [31:0]           req_lane2,
  input  logic [31:0]           req_lane3,
  input  logic [31:0]           req_lane4,
  input  logic [31:0]           req_lane5,
  input  logic [31:0]           req_lane6,
  input  logic [31:0]           req_lane7,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  granted,
  output logic [LANE_W-1:0]     grant_lane,
  output logic [PTR_W-1:0]      grant_queue
);

  localparam int PORT_AW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int LIDX_W  = (LANES > 1) ? $clog2(LANES) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CALC = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;

  logic [LANE_CNT_W-1:0] lane_count;

  // Lane selection on the incoming transaction.
  logic [MAX_LANES-1:0][31:0] req_all;
  logic                       port_ok;
  logic                       sel_hit;
  logic [LANE_W-1:0]          sel_lane;
  logic [QUEUES-1:0]          sel_mask;

  // Transaction held across the memory read.
  logic [PORT_AW-1:0] port_q;
  logic               hit_q;
  logic [LANE_W-1:0]  lane_q;
  logic [QUEUES-1:0]  mask_q;

  logic                        accept;
  logic                        finish;
  logic                        mem_wr_en;
  logic [LANES-1:0][PTR_W-1:0] rd_row;
  logic [LANES-1:0][PTR_W-1:0] wr_row;
  logic [PTR_W-1:0]            start_ptr;
  rr_grant_t                   grant;

  assign req_all = {req_lane7, req_lane6, req_lane5, req_lane4,
                    req_lane3, req_lane2, req_lane1, req_lane0};

  assign port_ok = 32'(out_port) < 32'(PORTS);

  // Strict priority: lowest enabled lane with any eligible queue wins.
  always_comb begin
    sel_hit  = 1'b0;
    sel_lane = '0;
    sel_mask = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if ((LANE_CNT_W'(i) < lane_count) && (|req_all[i][QUEUES-1:0])) begin
        sel_hit  = 1'b1;
        sel_lane = LANE_W'(i);
        sel_mask = req_all[i][QUEUES-1:0];
      end
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // Finish once the output register is free or being emptied.
  assign finish   = (state == S_CALC) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      lane_count <= LANE_COUNT_RST;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        lane_count <= cfg_wr_data;
      end
    end
  end

  // Capture the transaction; an out-of-range port never hits.
  always_ff @(posedge clk) begin
    if (accept) begin
      port_q <= PORT_AW'(out_port);
      hit_q  <= sel_hit && port_ok;
      lane_q <= sel_lane;
      mask_q <= sel_mask;
    end
  end

  prra_ptr_mem #(
    .PORTS(PORTS),
    .LANES(LANES)
  ) u_ptr_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(PORT_AW'(out_port)),
    .rd_row (rd_row),
    .wr_en  (mem_wr_en),
    .wr_addr(port_q),
    .wr_row (wr_row)
  );

  assign start_ptr = rd_row[lane_q[LIDX_W-1:0]];

  prra_rr_pick #(
    .QUEUES(QUEUES)
  ) u_rr_pick (
    .mask (mask_q),
    .start(start_ptr),
    .grant(grant)
  );

  // Write back the row with only the granted lane's pointer advanced.
  always_comb begin
    wr_row                       = rd_row;
    wr_row[lane_q[LIDX_W-1:0]]   = grant.ptr_next;
  end

  assign mem_wr_en = finish && hit_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      granted     <= hit_q;
      grant_lane  <= hit_q ? lane_q : '0;
      grant_queue <= hit_q ? grant.queue : '0;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CALC))
    else $error("accepted transaction did not start the search");

  a_write_in_calc: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> (state == S_CALC) && hit_q)
    else $error("pointer write outside a granted search");

  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted) |-> (32'(grant_queue) < 32'(QUEUES))
                               && (32'(grant_lane) < 32'(LANES)))
    else $error("grant out of range");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (grant_lane == '0) && (grant_queue == '0))
    else $error("no-grant result carries nonzero lane or queue");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(grant_queue))
    else $error("stalled result dropped or changed");
`endif

endmodule

[tb/sv/priority_round_robin_arbiter_test.sv]
// Self-checking testbench for priority_round_robin_arbiter: directed vectors, then random
// transactions under several idle and stall mixes, scored against hand-written grants or
// a local allocator model. Depends on prra_pkg and the arbiter RTL only.
module priority_round_robin_arbiter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import prra_pkg::*;

  localparam int QUIET_LIMIT     = 2000; // cycles with no handshake on either channel
  localparam int ITEMS_PER_PHASE = 160;
  localparam int PHASES          = 8;
  localparam int LONG_HOLD       = 60;

  typedef logic [MAX_LANES-1:0][31:0] req_set_t;

  typedef struct packed {
    logic              granted;
    logic [LANE_W-1:0] lane;
    logic [PTR_W-1:0]  queue;
  } grant_t;

  // One directed vector: lane count to run it under, the transaction, and an
  // optional hand-written grant (otherwise the allocator model decides).
  typedef struct {
    logic [LANE_CNT_W-1:0] lanes_cfg;
    logic [PORT_W-1:0]     port;
    req_set_t              req;
    bit                    typed;
    grant_t                grant;
  } vector_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [LANE_CNT_W-1:0] cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PORT_W-1:0]     out_port = '0;
  logic [31:0]           req_lane0 = '0;
  logic [31:0]           req_lane1 = '0;
  logic [31:0]           req_lane2 = '0;
  logic [31:0]           req_lane3 = '0;
  logic [31:0]           req_lane4 = '0;
  logic [31:0]           req_lane5 = '0;
  logic [31:0]           req_lane6 = '0;
  logic [31:0]           req_lane7 = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  granted;
  logic [LANE_W-1:0]     grant_lane;
  logic [PTR_W-1:0]      grant_queue;

  // Allocator model state: one round-robin pointer per port and lane.
  logic [PTR_W-1:0]      rr_ptr [PORTS_DEF*LANES_DEF];
  logic [LANE_CNT_W-1:0] lane_count_model = LANE_COUNT_RST;

  grant_t     pending_grants [$];
  vector_t    directed [$];
  idle_mode_t idle_mode = IDLE_NONE;
  int         errors = 0;
  int         quiet_cycles = 0;
  int         hold_req = 0;
  int         hold_left = 0;
  logic [LANE_CNT_W-1:0] phase_lanes [PHASES];

  priority_round_robin_arbiter i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_port    (out_port),
    .req_lane0   (req_lane0),
    .req_lane1   (req_lane1),
    .req_lane2   (req_lane2),
    .req_lane3   (req_lane3),
    .req_lane4   (req_lane4),
    .req_lane5   (req_lane5),
    .req_lane6   (req_lane6),
    .req_lane7   (req_lane7),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .granted     (granted),
    .grant_lane  (grant_lane),
    .grant_queue (grant_queue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Allocate one output port: walk lanes in strict priority up to the
  // configured count (saturated at the lane maximum), round-robin within a
  // lane from its stored pointer, and advance the pointer past the winner.
  function automatic grant_t allocate(input logic [PORT_W-1:0] port, input req_set_t req);
    grant_t g;
    int     lanes;
    int     slot;
    int     q;
    g = '0;
    lanes = (lane_count_model > MAX_LANES) ? MAX_LANES : int'(lane_count_model);
    for (int l = 0; l < lanes; l++) begin
      slot = int'(port) * MAX_LANES + l;
      if (!g.granted && req[l] != '0) begin
        for (int i = 0; i < MAX_QUEUES; i++) begin
          q = (int'(rr_ptr[slot]) + i) % MAX_QUEUES;
          if (!g.granted && req[l][q]) begin
            g.granted = 1'b1;
            g.lane = LANE_W'(l);
            g.queue = PTR_W'(q);
            rr_ptr[slot] = PTR_W'(q + 1);
          end
        end
      end
    end
    return g;
  endfunction

  function automatic req_set_t lane_req(input int l, input logic [31:0] mask);
    req_set_t r;
    r = '0;
    r[l] = mask;
    return r;
  endfunction

  function automatic vector_t vec(input logic [LANE_CNT_W-1:0] lc, input logic [PORT_W-1:0] port,
                                  input req_set_t req, input bit typed, input logic g,
                                  input int l, input int q);
    vector_t v;
    v.lanes_cfg = lc;
    v.port = port;
    v.req = req;
    v.typed = typed;
    v.grant.granted = g;
    v.grant.lane = LANE_W'(l);
    v.grant.queue = PTR_W'(q);
    return v;
  endfunction

  // Append one vector to the directed list.
  task automatic enlist(input vector_t v);
    directed.insert(directed.size(), v);
  endtask

  // Mix of empty, single-bit, sparse, dense, full and contiguous masks so
  // that lower lanes are often empty and pointers wrap in every way.
  function automatic logic [31:0] rand_mask();
    logic [31:0] m;
    case ($urandom_range(0, 7))
      0, 1, 2: m = '0;
      3:       m = 32'h1 << $urandom_range(0, 31);
      4:       m = $urandom;
      5:       m = $urandom & $urandom & $urandom;
      6:       m = '1;
      default: m = (32'hFFFF_FFFF >> $urandom_range(24, 31)) << $urandom_range(0, 31);
    endcase
    return m;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 74;
      IDLE_BOTH:   return $urandom_range(0, 99) < 36;
      default:     return 1'b0;
    endcase
  endfunction

  // Offer one transaction, hold it until accepted, then record the grant it
  // must produce. Returns at the accepting edge with in_valid still high.
  task automatic send(input logic [PORT_W-1:0] port, input req_set_t req, input bit typed,
                      input grant_t typed_grant);
    grant_t g;
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    out_port  <= port;
    req_lane0 <= req[0];
    req_lane1 <= req[1];
    req_lane2 <= req[2];
    req_lane3 <= req[3];
    req_lane4 <= req[4];
    req_lane5 <= req[5];
    req_lane6 <= req[6];
    req_lane7 <= req[7];
    do @(posedge clk); while (in_stall);
    g = allocate(port, req);
    pending_grants.insert(pending_grants.size(), typed ? typed_grant : g);
  endtask

  // Drop valid and wait until every outstanding grant has been delivered.
  task automatic wait_for_grants();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // Write lane_count only with the arbiter idle.
  task automatic set_lane_count(input logic [LANE_CNT_W-1:0] value);
    wait_for_grants();
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lane_count_model = value;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver: free-running, random stalls by mode, or one long hold-off when
  // requested so the arbiter fills up and pushes back on its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_req - 1;
      hold_req = 0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_stall <= ($urandom_range(0, 99) < 74);
        IDLE_BOTH:     out_stall <= ($urandom_range(0, 99) < 36);
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  // Score each delivered grant against the oldest pending one.
  always @(posedge clk) begin : score_grants
    grant_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected grant, actual granted=%0d lane=%0d queue=%0d",
                 $time, granted, grant_lane, grant_queue);
      end else begin
        want = pending_grants.pop_front();
        check_field("granted", want.granted, granted);
        check_field("grant_lane", want.lane, grant_lane);
        check_field("grant_queue", want.queue, grant_queue);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    vector_t          v;
    req_set_t         req;
    logic [PORT_W-1:0] port;

    for (int i = 0; i < PORTS_DEF * LANES_DEF; i++) rr_ptr[i] = '0;
    phase_lanes = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd9, 4'd8};

    // Directed vectors. Typed grants follow from the pointers after reset.
    // Nothing eligible: no grant, pointers untouched.
    enlist(vec(4'd8, 5'd0, '0, 1, 0, 0, 0));
    // Full lane 0: consecutive grants rotate through queues 0 and 1.
    enlist(vec(4'd8, 5'd0, lane_req(0, '1), 1, 1, 0, 0));
    enlist(vec(4'd8, 5'd0, lane_req(0, '1), 1, 1, 0, 1));
    // Top queue of top lane on top port, then pointer wrap back to queue 0.
    enlist(vec(4'd8, 5'd31, lane_req(7, 32'h8000_0000), 1, 1, 7, 31));
    enlist(vec(4'd8, 5'd31, lane_req(7, 32'h8000_0000), 1, 1, 7, 31));
    enlist(vec(4'd8, 5'd31, lane_req(7, 32'h1), 1, 1, 7, 0));
    enlist(vec(4'd8, 5'd31, lane_req(7, 32'h1), 1, 1, 7, 0));
    // Strict priority: lower lane wins, and a lone request wraps past the pointer.
    enlist(vec(4'd8, 5'd5, lane_req(3, 32'h10) | lane_req(4, 32'hFF), 1, 1, 3, 4));
    enlist(vec(4'd8, 5'd5, '1, 1, 1, 0, 0));
    enlist(vec(4'd8, 5'd5, lane_req(3, 32'h10), 1, 1, 3, 4));
    enlist(vec(4'd8, 5'd12, lane_req(2, 32'h0F0F_0000) | lane_req(5, 32'h3),
               0, 0, 0, 0));
    // One lane in use: higher lanes are ignored.
    enlist(vec(4'd1, 5'd2, lane_req(1, 32'hF), 1, 0, 0, 0));
    enlist(vec(4'd1, 5'd2, lane_req(0, 32'h2), 1, 1, 0, 1));
    // Lane count zero: nothing is searched.
    enlist(vec(4'd0, 5'd2, lane_req(0, '1), 1, 0, 0, 0));
    // Lane counts above the maximum saturate, so lane 7 is still searched.
    enlist(vec(4'd15, 5'd3, lane_req(7, 32'h4), 1, 1, 7, 2));
    enlist(vec(4'd9, 5'd3, lane_req(7, 32'h4), 1, 1, 7, 2));
    // Four lanes: lane 3 is the last one looked at.
    enlist(vec(4'd4, 5'd7, lane_req(3, 32'h8000_0000) | lane_req(4, 32'h1),
               1, 1, 3, 31));
    enlist(vec(4'd4, 5'd7, lane_req(4, 32'h1), 1, 0, 0, 0));
    enlist(vec(4'd8, 5'd20, lane_req(6, 32'hAAAA_5555), 0, 0, 0, 0));
    enlist(vec(4'd8, 5'd20, lane_req(6, 32'hAAAA_5555), 0, 0, 0, 0));
    enlist(vec(4'd8, 5'd9, lane_req(1, 32'h0001_0000) | lane_req(2, 32'hFFFF_0000),
               0, 0, 0, 0));
    enlist(vec(4'd8, 5'd0, lane_req(0, '1), 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      v = directed[i];
      if (v.lanes_cfg != lane_count_model) set_lane_count(v.lanes_cfg);
      send(v.port, v.req, v.typed, v.grant);
    end

    // Random phases: each one drains, rewrites lane_count and changes the
    // idle mix. Favor a few ports so their pointers rotate many times.
    for (int p = 0; p < PHASES; p++) begin
      set_lane_count(phase_lanes[p]);
      idle_mode = idle_mode_t'(p % 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold off the receiver while transactions keep coming.
        if (idle_mode == IDLE_NONE && n == ITEMS_PER_PHASE / 2) hold_req = LONG_HOLD;
        port = ($urandom_range(0, 9) < 7) ? PORT_W'($urandom_range(0, 3))
                                          : PORT_W'($urandom_range(0, 31));
        req = '0;
        if ($urandom_range(0, 9) != 0) begin
          for (int l = 0; l < MAX_LANES; l++) req[l] = rand_mask();
        end
        send(port, req, 1'b0, '0);
      end
    end

    wait_for_grants();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/prra_pkg.sv
src/prra_ptr_mem.sv
src/prra_rr_pick.sv
src/priority_round_robin_arbiter.sv
tb/sv/priority_round_robin_arbiter_test.sv
